// File: sv/bilinear_rgb_texture_sampler_assert.svh
// Assertion macros for the texture sampler. They expect clk and rst_n in scope.
`ifndef BILINEAR_RGB_TEXTURE_SAMPLER_ASSERT_SVH
`define BILINEAR_RGB_TEXTURE_SAMPLER_ASSERT_SVH

// Condition that must hold at every edge out of reset.
`define BRTS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sampler check failed");

// Same-cycle implication.
`define BRTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sampler implication failed");

// Next-cycle implication.
`define BRTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sampler sequence failed");

`endif

// File: sv/brts_pkg.sv
package brts_pkg;

  // Fixed field widths of the stream items and registers.
  localparam int INDEX_W    = 16;
  localparam int DIM_W      = 9;
  localparam int COORD_INT  = 2;
  localparam int CFG_ADDR_W = 2;

  // Item kinds carried on tuser.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

endpackage

// File: sv/brts_texmem.sv
// Texel store copy: one write port, two registered read ports.
module brts_texmem #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int DATA_W = 96
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports hold their data while the pipeline stalls.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: sv/bilinear_rgb_texture_sampler.sv
// Channel  Dir  Beat contents
// in_      in   tuser: kind; tdata: texel_index, red, green, blue, u, v
// out_     out  tuser: image_empty; tdata: red, green, blue
// cfg_     in   cfg_addr: register index; cfg_data: register value
//
// Five register stages: coordinate multiply, address and weight forming,
// texel store read, weighted terms, sum and saturate. One beat per cycle
// enters while no stage stalls; a sample result leaves from stage five.
// Write beats update the store in the read stage and give no result. Each
// stage stalls only when it is full and the stage after it cannot take
// its beat. Reset clears valid bits and size registers, not the store.
module bilinear_rgb_texture_sampler
  import brts_pkg::*;
#(
  parameter int MAX_TEXELS    = 65536,
  parameter int CHANNEL_BITS  = 32,
  parameter int FRACTION_BITS = 16,
  localparam int CW     = CHANNEL_BITS,
  localparam int F      = FRACTION_BITS,
  localparam int UVW    = F + COORD_INT,
  localparam int IN_BITS = INDEX_W + 3 * CW + 2 * UVW,
  localparam int IN_TW  = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * CW + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,   // texel_index, red, green, blue, u, v
  input  logic                  in_tuser,   // kind
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TW-1:0]     out_tdata,  // red, green, blue
  output logic                  out_tuser,  // image_empty
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data
);

  localparam int PW    = UVW + DIM_W;
  localparam int RW    = PW - F;
  localparam int AW    = $clog2(MAX_TEXELS);
  localparam int XW    = ((AW > 2 * DIM_W) ? AW : 2 * DIM_W) + 1;
  localparam int WW    = F + 1;
  localparam int TW    = CW + 1;
  localparam int SW    = CW + 3;
  localparam int TEXW  = 3 * CW;
  localparam logic [WW-1:0] ONE = {1'b1, {F{1'b0}}};

  // Configuration registers.
  logic [DIM_W-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valids and enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic e1, e2, e3, e4, e5;

  assign e5 = !v5_r || out_tready;
  assign e4 = !v4_r || e5;
  assign e3 = !v3_r || e4;
  assign e2 = !v2_r || e3;
  assign e1 = !v1_r || e2;
  assign in_tready = e1;

  // Input beat fields.
  logic [INDEX_W-1:0] in_idx;
  logic [TEXW-1:0]    in_texel;
  logic [UVW-1:0]     in_u, in_v;

  assign in_idx   = in_tdata[INDEX_W-1:0];
  assign in_texel = in_tdata[INDEX_W +: TEXW];
  assign in_u     = in_tdata[INDEX_W + TEXW +: UVW];
  assign in_v     = in_tdata[INDEX_W + TEXW + UVW +: UVW];

  // Stage 1: scale coordinates by the image size.
  logic               kind1_r, empty1_r;
  logic [INDEX_W-1:0] idx1_r;
  logic [TEXW-1:0]    tex1_r;
  logic [PW-1:0]      pu1_r, pv1_r, pu1_nxt, pv1_nxt;

  assign pu1_nxt = PW'(in_u) * PW'(width_r);
  assign pv1_nxt = PW'(in_v) * PW'(height_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (e1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (e1) begin
      kind1_r  <= in_tuser;
      empty1_r <= (width_r == '0) || (height_r == '0);
      idx1_r   <= in_idx;
      tex1_r   <= in_texel;
      pu1_r    <= pu1_nxt;
      pv1_r    <= pv1_nxt;
    end
  end

  // Stage 2: clamped corner addresses and corner weights.
  // Corner order: 0 = (r,c), 1 = (r,c+1), 2 = (r+1,c), 3 = (r+1,c+1).
  logic               kind2_r, empty2_r;
  logic [INDEX_W-1:0] idx2_r;
  logic [TEXW-1:0]    tex2_r;
  logic [XW-1:0]      addr2_r [4];
  logic [XW-1:0]      addr2_nxt [4];
  logic [3:0]         oob2_r, oob2_nxt;
  logic [WW-1:0]      w2_r [4];
  logic [WW-1:0]      w2_nxt [4];

  logic [RW-1:0]    row, col;
  logic [RW:0]      row_p1, col_p1;
  logic [DIM_W-1:0] hm1, wm1, ri0, ri1, ci0, ci1;
  logic [WW-1:0]    fr, fc, omr, omc;
  logic [2*WW-1:0]  wprod [4];
  logic [XW-1:0]    base0, base1;

  always_comb begin
    row    = pv1_r[PW-1:F];
    col    = pu1_r[PW-1:F];
    row_p1 = {1'b0, row} + 1'b1;
    col_p1 = {1'b0, col} + 1'b1;
    hm1    = height_r - 1'b1;
    wm1    = width_r - 1'b1;
    ri0    = (row < RW'(hm1)) ? row[DIM_W-1:0] : hm1;
    ri1    = (row_p1 < (RW + 1)'(hm1)) ? row_p1[DIM_W-1:0] : hm1;
    ci0    = (col < RW'(wm1)) ? col[DIM_W-1:0] : wm1;
    ci1    = (col_p1 < (RW + 1)'(wm1)) ? col_p1[DIM_W-1:0] : wm1;
    base0  = XW'(ri0) * XW'(width_r);
    base1  = XW'(ri1) * XW'(width_r);
    addr2_nxt[0] = base0 + XW'(ci0);
    addr2_nxt[1] = base0 + XW'(ci1);
    addr2_nxt[2] = base1 + XW'(ci0);
    addr2_nxt[3] = base1 + XW'(ci1);
    for (int i = 0; i < 4; i++) begin
      oob2_nxt[i] = addr2_nxt[i] >= XW'(MAX_TEXELS);
    end
    fr  = {1'b0, pv1_r[F-1:0]};
    fc  = {1'b0, pu1_r[F-1:0]};
    omr = ONE - fr;
    omc = ONE - fc;
    wprod[0] = (2 * WW)'(omr) * (2 * WW)'(omc);
    wprod[1] = (2 * WW)'(omr) * (2 * WW)'(fc);
    wprod[2] = (2 * WW)'(fr) * (2 * WW)'(omc);
    wprod[3] = (2 * WW)'(fr) * (2 * WW)'(fc);
    for (int i = 0; i < 4; i++) begin
      w2_nxt[i] = wprod[i][F +: WW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (e2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e2) begin
      kind2_r  <= kind1_r;
      empty2_r <= empty1_r;
      idx2_r   <= idx1_r;
      tex2_r   <= tex1_r;
      oob2_r   <= oob2_nxt;
      for (int i = 0; i < 4; i++) begin
        addr2_r[i] <= addr2_nxt[i];
        w2_r[i]    <= w2_nxt[i];
      end
    end
  end

  // Stage 3: texel store read; write beats update the store here.
  logic          empty3_r;
  logic [3:0]    oob3_r;
  logic [WW-1:0] w3_r [4];
  logic          wr_en;
  logic [TEXW-1:0] rd_data [4];

  assign wr_en = e3 && v2_r && (kind2_r == KIND_WRITE)
              && (XW'(idx2_r) < XW'(MAX_TEXELS));

  brts_texmem #(.DEPTH(MAX_TEXELS), .ADDR_W(AW), .DATA_W(TEXW)) u_mem_top (
    .clk       (clk),
    .rd_en     (e3),
    .wr_en     (wr_en),
    .wr_addr   (AW'(idx2_r)),
    .wr_data   (tex2_r),
    .rd_addr_a (addr2_r[0][AW-1:0]),
    .rd_addr_b (addr2_r[1][AW-1:0]),
    .rd_data_a (rd_data[0]),
    .rd_data_b (rd_data[1])
  );

  brts_texmem #(.DEPTH(MAX_TEXELS), .ADDR_W(AW), .DATA_W(TEXW)) u_mem_bot (
    .clk       (clk),
    .rd_en     (e3),
    .wr_en     (wr_en),
    .wr_addr   (AW'(idx2_r)),
    .wr_data   (tex2_r),
    .rd_addr_a (addr2_r[2][AW-1:0]),
    .rd_addr_b (addr2_r[3][AW-1:0]),
    .rd_data_a (rd_data[2]),
    .rd_data_b (rd_data[3])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (e3) begin
      v3_r <= v2_r && (kind2_r == KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      empty3_r <= empty2_r;
      oob3_r   <= oob2_r;
      for (int i = 0; i < 4; i++) begin
        w3_r[i] <= w2_r[i];
      end
    end
  end

  // Stage 4: one truncated weighted term per corner and channel.
  logic             empty4_r;
  logic [TW-1:0]    term4_r [12];
  logic [TW-1:0]    term4_nxt [12];
  logic [CW+WW-1:0] tprod [12];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 3; k++) begin
        tprod[c*3+k] = (CW + WW)'(rd_data[c][k*CW +: CW]) * (CW + WW)'(w3_r[c]);
        term4_nxt[c*3+k] = oob3_r[c] ? '0 : tprod[c*3+k][F +: TW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (e4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e4) begin
      empty4_r <= empty3_r;
      for (int i = 0; i < 12; i++) begin
        term4_r[i] <= term4_nxt[i];
      end
    end
  end

  // Stage 5: sum the four terms, saturate (black for an empty image), and hold the result beat.
  logic          empty5_r;
  logic [CW-1:0] chan5_r [3];
  logic [CW-1:0] chan5_nxt [3];
  logic [SW-1:0] sum [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k] = SW'(term4_r[k]) + SW'(term4_r[3+k]) + SW'(term4_r[6+k])
             + SW'(term4_r[9+k]);
      if (empty4_r) begin
        chan5_nxt[k] = '0;
      end else if (|sum[k][SW-1:CW]) begin
        chan5_nxt[k] = '1;
      end else begin
        chan5_nxt[k] = sum[k][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (e5) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (e5) begin
      empty5_r <= empty4_r;
      for (int k = 0; k < 3; k++) begin
        chan5_r[k] <= chan5_nxt[k];
      end
    end
  end

  assign out_tvalid = v5_r;
  assign out_tuser  = empty5_r;
  assign out_tdata  = OUT_TW'({chan5_r[2], chan5_r[1], chan5_r[0]});

  // Checks on the pipeline control and on empty-image results.
  `include "bilinear_rgb_texture_sampler_assert.svh"

  `BRTS_ASSERT_IMPL(a_empty_black, out_tvalid && out_tuser, out_tdata == '0)
  `BRTS_ASSERT_IMPL(a_stall_from_out, !in_tready, out_tvalid && !out_tready)
  `BRTS_ASSERT_NEXT(a_term_held, v4_r && !e5, v4_r && $stable(empty4_r))

endmodule

// File: tb/bilinear_rgb_texture_sampler_chk.sv
// Watches the input, result and register channels, predicts each sample result
// and compares it with the beat that leaves the sampler.
module bilinear_rgb_texture_sampler_chk
  import brts_pkg::*;
#(
  parameter int IN_TW  = 152,
  parameter int OUT_TW = 96
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_TW-1:0]     out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic        empty;
    logic [31:0] blue;
    logic [31:0] green;
    logic [31:0] red;
  } pixel_t;

  logic [95:0]      texels [int];
  logic [DIM_W-1:0] tex_w, tex_h;
  pixel_t           pixel_queue [$];

  assign pending = pixel_queue.size();

  // Texel read with clamp to the last row and column; beyond the store is black.
  function automatic logic [95:0] texel_at(longint r, longint c);
    longint rr, cc, a;
    rr = (r < tex_h - 1) ? r : tex_h - 1;
    cc = (c < tex_w - 1) ? c : tex_w - 1;
    a = rr * tex_w + cc;
    if (a >= 65536 || !texels.exists(int'(a))) return '0;
    return texels[int'(a)];
  endfunction

  function automatic pixel_t sample_pixel(logic [17:0] u, logic [17:0] v);
    pixel_t p;
    longint pv, pu, row, col, fr, fc, w[4], sum;
    logic [95:0] t[4];
    p = '0;
    if (tex_w == 0 || tex_h == 0) begin
      p.empty = 1'b1;
      return p;
    end
    pv = longint'(v) * tex_h;
    pu = longint'(u) * tex_w;
    row = pv >> 16;
    col = pu >> 16;
    fr = pv & 16'hFFFF;
    fc = pu & 16'hFFFF;
    w[0] = ((65536 - fr) * (65536 - fc)) >> 16;
    w[1] = (fr * (65536 - fc)) >> 16;
    w[2] = (fr * fc) >> 16;
    w[3] = ((65536 - fr) * fc) >> 16;
    t[0] = texel_at(row, col);
    t[1] = texel_at(row + 1, col);
    t[2] = texel_at(row + 1, col + 1);
    t[3] = texel_at(row, col + 1);
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int n = 0; n < 4; n++)
        sum += (longint'(t[n][32*k +: 32]) * w[n]) >> 16;
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      p[32*k +: 32] = sum[31:0];
    end
    return p;
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst_n) begin
      tex_w = '0;
      tex_h = '0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_addr == REG_IMAGE_WIDTH) tex_w = cfg_data;
        else if (cfg_addr == REG_IMAGE_HEIGHT) tex_h = cfg_data;
      end
      // Input beats: writes update the store copy, samples queue a prediction.
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_WRITE)
          texels[int'(in_tdata[15:0])] = in_tdata[111:16];
        else
          pixel_queue.push_back(sample_pixel(in_tdata[129:112], in_tdata[147:130]));
      end
      // Result beats are compared with the oldest prediction.
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[95:0]};
        if (pixel_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected r %h g %h b %h e %b, got r %h g %h b %h e %b",
                       want.red, want.green, want.blue, want.empty,
                       got.red, got.green, got.blue, got.empty);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/bilinear_rgb_texture_sampler_tb.sv
// Drives register settings, texel writes and sample requests into the sampler.
module bilinear_rgb_texture_sampler_tb;
  import brts_pkg::*;

  localparam int IN_TW  = 152;
  localparam int OUT_TW = 96;
  localparam int STALL_LIMIT = 5000;

  logic                  clk, rst_n;
  logic                  in_tvalid, in_tready, in_tuser;
  logic [IN_TW-1:0]      in_tdata;
  logic                  out_tvalid, out_tready, out_tuser;
  logic [OUT_TW-1:0]     out_tdata;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DIM_W-1:0]      cfg_data;
  int                    fail_count, pending;
  int                    send_idle, recv_idle, idle_cycles;
  bit                    hold_recv;
  int                    tex_w, tex_h;

  bilinear_rgb_texture_sampler dut (.*);

  bilinear_rgb_texture_sampler_chk #(.IN_TW(IN_TW), .OUT_TW(OUT_TW)) chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, or a long hold-off on request.
  always @(posedge clk) begin
    out_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  // Watchdog on cycles with no accepted beat of any kind.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("bilinear_rgb_texture_sampler_tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value[DIM_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // The valid stays high after an accepted beat so the next one can follow
  // directly; idling and settling drop it.
  task automatic send_beat(logic kind, logic [15:0] idx, logic [95:0] rgb,
                           logic [17:0] u, logic [17:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'd0, v, u, rgb, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [95:0] rand_rgb();
    case ($urandom_range(3))
      0: return '1;
      1: return {$urandom_range(3), $urandom_range(3), $urandom_range(3)} << 16;
      default: return {$urandom, $urandom, $urandom};
    endcase
  endfunction

  // Waits for all results, then lets the pipeline drain before a register write.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Sets the image size and fills every texel that samples can reach.
  task automatic new_image(int w, int h);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
    tex_w = w;
    tex_h = h;
    for (int i = 0; i < w * h && i < 65536; i++)
      send_beat(KIND_WRITE, i[15:0], rand_rgb(), 18'($urandom), 18'($urandom));
  endtask

  function automatic logic [17:0] rand_coord();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 18'h10000;
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0 && tex_w * tex_h > 0)
        send_beat(KIND_WRITE, 16'($urandom_range(tex_w * tex_h - 1)), rand_rgb(),
                  18'($urandom), 18'($urandom));
      else
        send_beat(KIND_SAMPLE, 16'($urandom), {$urandom, $urandom, $urandom},
                  rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_addr = '0; cfg_data = '0;
    hold_recv = 1'b0; send_idle = 0; recv_idle = 0;
    tex_w = 0; tex_h = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: samples of an empty image, then corners and edges of small images.
    send_beat(KIND_SAMPLE, 16'hFFFF, '1, '1, '1);
    send_beat(KIND_SAMPLE, '0, '0, '0, '0);
    new_image(1, 1);
    send_beat(KIND_SAMPLE, '0, '0, '1, '1);
    send_beat(KIND_SAMPLE, '0, '0, 18'h08000, 18'h08000);
    new_image(3, 2);
    send_beat(KIND_SAMPLE, '0, '0, '0, '0);
    send_beat(KIND_SAMPLE, '0, '0, '1, '0);
    send_beat(KIND_SAMPLE, '0, '0, '0, '1);
    send_beat(KIND_SAMPLE, '0, '0, 18'h10000, 18'h10000);
    send_beat(KIND_SAMPLE, '0, '0, 18'h0FFFF, 18'h07FFF);
    // Saturation: a full-scale image sampled inside and beyond its edges.
    settle();
    for (int i = 0; i < 6; i++) send_beat(KIND_WRITE, i[15:0], '1, '0, '0);
    send_beat(KIND_SAMPLE, '0, '0, 18'h0AAAA, 18'h05555);
    send_beat(KIND_SAMPLE, '0, '0, 18'h1FFFF, 18'h2FFFF);
    // Width set to zero with a nonzero height gives an empty image again.
    new_image(0, 4);
    send_beat(KIND_SAMPLE, '0, '0, 18'h12345, 18'h23456);

    // Random phases with the three idling mixes and several sizes.
    send_idle = 34; recv_idle = 53;
    new_image(5, 7);
    random_phase(120);
    new_image(256, 1);
    random_phase(80);
    send_idle = 53; recv_idle = 34;
    new_image(2, 3);
    random_phase(120);
    new_image(16, 16);
    random_phase(80);
    send_idle = 0; recv_idle = 0;
    // Receiver holds off while samples keep coming, so the input stalls.
    fork
      begin
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
      end
      random_phase(60);
    join
    new_image(1, 256);
    random_phase(80);
    new_image(4, 3);
    random_phase(80);

    settle();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("bilinear_rgb_texture_sampler_tb OK");
    else
      $display("bilinear_rgb_texture_sampler_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/brts_pkg.sv
sv/brts_texmem.sv
sv/bilinear_rgb_texture_sampler.sv
tb/bilinear_rgb_texture_sampler_chk.sv
tb/bilinear_rgb_texture_sampler_tb.sv
